// ----- hdl/permutation_cycle_counter_top_defines.svh -----
// assertion macros used by the permutation cycle counter controller
`ifndef PERMUTATION_CYCLE_COUNTER_TOP_DEFINES_SVH
`define PERMUTATION_CYCLE_COUNTER_TOP_DEFINES_SVH

// same-cycle implication, held off while in reset
`define PCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off while in reset
`define PCC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pcc_pkg.sv -----
package pcc_pkg;

  localparam int SuccW             = 11;
  localparam int CountW            = 11;
  localparam int MaxEntriesDefault = 1024;

  typedef enum logic [1:0] {
    StLoad,
    StCheck,
    StScan,
    StVisit
  } state_e;

  typedef struct packed {
    logic [CountW-1:0] cycle_count;
    logic              bad_entry;
  } result_t;

endpackage

// ----- hdl/pcc_if.sv -----
interface pcc_in_if;
  logic                      valid;
  logic                      ready;
  logic [pcc_pkg::SuccW-1:0] successor;
  logic                      last;

  modport source (output valid, output successor, output last, input ready);
  modport sink (input valid, input successor, input last, output ready);
endinterface

interface pcc_out_if;
  logic                       valid;
  logic                       ready;
  logic [pcc_pkg::CountW-1:0] cycle_count;
  logic                       bad_entry;

  modport source (output valid, output cycle_count, output bad_entry, input ready);
  modport sink (input valid, input cycle_count, input bad_entry, output ready);
endinterface

// ----- hdl/pcc_ram.sv -----
module pcc_ram #(
  parameter int Width = 1,
  parameter int Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/pcc_ctrl.sv -----
`include "permutation_cycle_counter_top_defines.svh"

module pcc_ctrl #(
  parameter int MaxEntries = pcc_pkg::MaxEntriesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pcc_pkg::SuccW-1:0]     successor_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pcc_pkg::result_t              result_o,
  output logic                          succ_we_o,
  output logic                          vis_we_o,
  output logic                          vis_wdata_o,
  output logic [$clog2(MaxEntries)-1:0] waddr_o,
  output logic [$clog2(MaxEntries)-1:0] succ_wdata_o,
  output logic [$clog2(MaxEntries)-1:0] raddr_o,
  input  logic [$clog2(MaxEntries)-1:0] succ_rdata_i,
  input  logic                          vis_rdata_i
);

  localparam int AddrW = $clog2(MaxEntries);
  localparam int LenW  = $clog2(MaxEntries + 1);
  localparam int SuccW = pcc_pkg::SuccW;
  localparam int CntW  = pcc_pkg::CountW;

  pcc_pkg::state_e  state_q, state_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  start_q, start_d;
  logic [LenW-1:0]  count_q, count_d;
  logic [SuccW-1:0] max_q, max_d;
  logic             err_q, err_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic             out_valid_q, out_valid_d;
  pcc_pkg::result_t result_q, result_d;

  logic accept, full, succ_ok, bad, scan_done, out_free, step_on;

  assign accept    = in_valid_i && in_ready_o;
  assign full      = (len_q == LenW'(MaxEntries));
  assign succ_ok   = (successor_i != '0) && (32'(successor_i) <= 32'(MaxEntries));
  // an entry pointing past the final length fails the whole set
  assign bad       = err_q || (32'(max_q) > 32'(len_q));
  assign scan_done = (start_q == len_q);
  assign out_free  = !out_valid_q || out_ready_i;
  // self-loop is caught here, the ram would still return the old mark
  assign step_on   = !vis_rdata_i && (32'(succ_rdata_i) < 32'(len_q))
                     && (succ_rdata_i != pos_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pcc_pkg::StLoad: begin
        if (accept && last_i) begin
          state_d = pcc_pkg::StCheck;
        end
      end
      pcc_pkg::StCheck: begin
        if (!bad) begin
          state_d = pcc_pkg::StScan;
        end else if (out_free) begin
          state_d = pcc_pkg::StLoad;
        end
      end
      pcc_pkg::StScan: begin
        if (!scan_done) begin
          state_d = pcc_pkg::StVisit;
        end else if (out_free) begin
          state_d = pcc_pkg::StLoad;
        end
      end
      pcc_pkg::StVisit: begin
        if (!step_on) begin
          state_d = pcc_pkg::StScan;
        end
      end
      default: state_d = pcc_pkg::StLoad;
    endcase
  end

  // memory controls and handshake
  always_comb begin
    in_ready_o   = 1'b0;
    succ_we_o    = 1'b0;
    vis_we_o     = 1'b0;
    vis_wdata_o  = 1'b0;
    waddr_o      = len_q[AddrW-1:0];
    succ_wdata_o = AddrW'(successor_i - SuccW'(1));
    raddr_o      = start_q[AddrW-1:0];
    case (state_q)
      pcc_pkg::StLoad: begin
        in_ready_o = 1'b1;
        // loading an entry also clears its visited mark
        if (accept && !full) begin
          succ_we_o = 1'b1;
          vis_we_o  = 1'b1;
          if (!succ_ok) begin
            succ_wdata_o = '0;
          end
        end
      end
      pcc_pkg::StVisit: begin
        waddr_o     = pos_q;
        vis_wdata_o = 1'b1;
        vis_we_o    = !vis_rdata_i;
        raddr_o     = succ_rdata_i;
      end
      default: begin
      end
    endcase
  end

  // datapath
  always_comb begin
    len_d       = len_q;
    start_d     = start_q;
    count_d     = count_q;
    max_d       = max_q;
    err_d       = err_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    result_d    = result_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      pcc_pkg::StLoad: begin
        if (accept) begin
          if (full) begin
            err_d = 1'b1;
          end else begin
            len_d = len_q + LenW'(1);
            if (!succ_ok) begin
              err_d = 1'b1;
            end else if (successor_i > max_q) begin
              max_d = successor_i;
            end
          end
        end
      end
      pcc_pkg::StCheck: begin
        start_d = '0;
        count_d = '0;
        if (bad && out_free) begin
          out_valid_d          = 1'b1;
          result_d.cycle_count = '0;
          result_d.bad_entry   = 1'b1;
          len_d                = '0;
          err_d                = 1'b0;
          max_d                = '0;
        end
      end
      pcc_pkg::StScan: begin
        pos_d = start_q[AddrW-1:0];
        if (scan_done && out_free) begin
          out_valid_d          = 1'b1;
          result_d.cycle_count = CntW'(count_q);
          result_d.bad_entry   = 1'b0;
          len_d                = '0;
          err_d                = 1'b0;
          max_d                = '0;
        end
      end
      pcc_pkg::StVisit: begin
        // an unvisited entry at the scan position opens a new cycle
        if (!vis_rdata_i && (pos_q == start_q[AddrW-1:0])) begin
          count_d = count_q + LenW'(1);
        end
        if (step_on) begin
          pos_d = succ_rdata_i;
        end else begin
          start_d = start_q + LenW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcc_pkg::StLoad;
      len_q       <= '0;
      start_q     <= '0;
      count_q     <= '0;
      max_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      start_q     <= start_d;
      count_q     <= count_d;
      max_q       <= max_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    result_q <= result_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  `PCC_ASSERT_NXT(a_last_starts_check, clk_i, rst_ni, accept && last_i,
                  state_q == pcc_pkg::StCheck, "last item did not start the check")
  `PCC_ASSERT_IMP(a_walk_in_range, clk_i, rst_ni, state_q == pcc_pkg::StVisit,
                  32'(pos_q) < 32'(len_q), "walk left the loaded range")
  `PCC_ASSERT_IMP(a_count_bounded, clk_i, rst_ni, state_q != pcc_pkg::StLoad,
                  (count_q <= start_q) ||
                  (state_q == pcc_pkg::StVisit && count_q == start_q + LenW'(1)),
                  "cycle count ran ahead of the scan")
  `PCC_ASSERT_IMP(a_scan_bounded, clk_i, rst_ni, state_q == pcc_pkg::StVisit,
                  start_q < len_q, "scan position passed the length")

endmodule

// ----- hdl/permutation_cycle_counter_top.sv -----
// channel   dir  payload                       handshake
// item_i    in   successor[10:0], last         valid/ready
// result_o  out  cycle_count[10:0], bad_entry  valid/ready
//
// loading accepts each valid item in the load state; the last item leads into the check
// state, then a scan over the entries: a scan and a visit state per start position and
// a further visit state per walk step up to the registered result, with one visited map
// read per cycle. a set with a bad entry ends after the check. input is not ready from
// the last item until the result is registered; a result waiting on result_o does not
// stop loading. async active-low reset, no clearing pass.
module permutation_cycle_counter_top #(
  parameter int MaxEntries = pcc_pkg::MaxEntriesDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pcc_in_if.sink    item_i,
  pcc_out_if.source result_o
);

  localparam int AddrW = $clog2(MaxEntries);

  logic             succ_we, vis_we, vis_wdata, vis_rdata;
  logic [AddrW-1:0] waddr, succ_wdata, raddr, succ_rdata;
  pcc_pkg::result_t result;

  pcc_ctrl #(
    .MaxEntries(MaxEntries)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .successor_i (item_i.successor),
    .last_i      (item_i.last),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .result_o    (result),
    .succ_we_o   (succ_we),
    .vis_we_o    (vis_we),
    .vis_wdata_o (vis_wdata),
    .waddr_o     (waddr),
    .succ_wdata_o(succ_wdata),
    .raddr_o     (raddr),
    .succ_rdata_i(succ_rdata),
    .vis_rdata_i (vis_rdata)
  );

  pcc_ram #(
    .Width(AddrW),
    .Depth(MaxEntries)
  ) u_succ_ram (
    .clk_i  (clk_i),
    .we_i   (succ_we),
    .waddr_i(waddr),
    .wdata_i(succ_wdata),
    .raddr_i(raddr),
    .rdata_o(succ_rdata)
  );

  pcc_ram #(
    .Width(1),
    .Depth(MaxEntries)
  ) u_vis_ram (
    .clk_i  (clk_i),
    .we_i   (vis_we),
    .waddr_i(waddr),
    .wdata_i(vis_wdata),
    .raddr_i(raddr),
    .rdata_o(vis_rdata)
  );

  assign result_o.cycle_count = result.cycle_count;
  assign result_o.bad_entry   = result.bad_entry;

endmodule
